### design/cpfb_pkg.sv
// ----------------------------------------------------------------------------
// cpfb_pkg: shared types and constants for the clipped pixel frame store
// Screen geometry, command codes, queue entry layout and back-end states.
// ----------------------------------------------------------------------------
package cpfb_pkg;

  // Screen geometry
  localparam int SCREEN_COLUMNS = 64;
  localparam int SCREEN_ROWS    = 32;
  localparam int STORE_DEPTH    = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int X_W            = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
  localparam int Y_W            = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int POS_W   = 16;
  localparam int COLOR_W = 8;

  // Command codes on the input port
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INVERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_XOR    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified operation carried to the back end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_INVERT,
    OP_XOR,
    OP_READ,
    OP_FILL
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               on_screen;
  } q_item_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MODIFY,
    BK_FILL
  } back_state_t;

  // Status from back end to front end
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

### design/clipped_pixel_framebuffer_top.sv
// ----------------------------------------------------------------------------
// clipped_pixel_framebuffer_top: byte-per-pixel frame store with clipping
// Write, invert, xor and read of single pixels, and fill with background.
//
//   channel  direction  ports
//   in       request    in_valid/in_ready, in_cmd, in_pos_x, in_pos_y, in_color
//   out      result     out_valid/out_ready, out_read_value, out_on_screen
//   cfg      register   cfg_valid/cfg_ready, cfg_data (background color)
//
// Write, off-screen and unused commands finish in the back end as they are taken;
// read, invert and xor add a modify state, set by the registered read of the store.
// Fill takes the word in idle, then writes the background color one pixel per
// cycle over the whole store.
// After reset the store is cleared one pixel per cycle; in_ready stays low
// meanwhile while cfg writes are taken. A two-word queue lets the front take
// up to two words while the back end works or out_ready is held low.
// ----------------------------------------------------------------------------
module clipped_pixel_framebuffer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cpfb_pkg::CMD_W-1:0]    in_cmd,
  input  logic [cpfb_pkg::POS_W-1:0]    in_pos_x,
  input  logic [cpfb_pkg::POS_W-1:0]    in_pos_y,
  input  logic [cpfb_pkg::COLOR_W-1:0]  in_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cpfb_pkg::COLOR_W-1:0]  out_read_value,
  output logic                          out_on_screen,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpfb_pkg::COLOR_W-1:0]  cfg_data
);
  import cpfb_pkg::*;

  back_status_t back_status;
  logic         q_push;
  logic         q_ready;
  q_item_t      q_push_item;
  logic         q_valid;
  q_item_t      q_pop_item;
  logic         q_pop;

  // Classify incoming words
  cpfb_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_color    (in_color),
    .back_status (back_status),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_item      (q_push_item)
  );

  // Decouple front and back
  cpfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_pop_item),
    .pop        (q_pop)
  );

  // Carry out operations on the store
  cpfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_item         (q_pop_item),
    .q_pop          (q_pop),
    .back_status    (back_status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_on_screen  (out_on_screen)
  );

endmodule

### design/cpfb_front.sv
// ----------------------------------------------------------------------------
// cpfb_front: request intake and classification
// Clips the point against the screen, forms the row-major address and
// reduces the command to one back-end operation.
// ----------------------------------------------------------------------------
module cpfb_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cpfb_pkg::CMD_W-1:0]    in_cmd,
  input  logic [cpfb_pkg::POS_W-1:0]    in_pos_x,
  input  logic [cpfb_pkg::POS_W-1:0]    in_pos_y,
  input  logic [cpfb_pkg::COLOR_W-1:0]  in_color,
  input  cpfb_pkg::back_status_t        back_status,
  input  logic                          q_ready,
  output logic                          q_push,
  output cpfb_pkg::q_item_t             q_item
);
  import cpfb_pkg::*;

  logic x_in;
  logic y_in;
  logic on_screen;
  op_t  op;

  // Clip against the screen: sign bit clear and below the limit
  assign x_in      = !in_pos_x[POS_W-1] && (in_pos_x < POS_W'(SCREEN_COLUMNS));
  assign y_in      = !in_pos_y[POS_W-1] && (in_pos_y < POS_W'(SCREEN_ROWS));
  assign on_screen = x_in && y_in;

  // Reduce command to an operation; drop pixel ops that fall off screen
  always_comb begin
    case (in_cmd)
      CMD_WRITE:  op = on_screen ? OP_WRITE  : OP_NONE;
      CMD_INVERT: op = on_screen ? OP_INVERT : OP_NONE;
      CMD_XOR:    op = on_screen ? OP_XOR    : OP_NONE;
      CMD_READ:   op = on_screen ? OP_READ   : OP_NONE;
      CMD_FILL:   op = OP_FILL;
      default:    op = OP_NONE;
    endcase
  end

  // Hold off intake while the store is being cleared after reset
  assign in_ready = q_ready && !back_status.clearing;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.op        = op;
    q_item.addr      = ADDR_W'(int'(in_pos_y[Y_W-1:0]) * SCREEN_COLUMNS
                               + int'(in_pos_x[X_W-1:0]));
    q_item.color     = in_color;
    q_item.on_screen = on_screen;
  end

endmodule

### design/cpfb_queue.sv
// ----------------------------------------------------------------------------
// cpfb_queue: small FIFO between front and back
// Lets the front accept while the back is busy on a longer operation.
// ----------------------------------------------------------------------------
module cpfb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cpfb_pkg::q_item_t push_item,
  output logic              push_ready,
  output logic              pop_valid,
  output cpfb_pkg::q_item_t pop_item,
  input  logic              pop
);
  import cpfb_pkg::*;

  q_item_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### design/cpfb_back.sv
// ----------------------------------------------------------------------------
// cpfb_back: frame store and operation sequencer
// Owns the pixel memory, the background color register and the result
// register; runs read-modify-write, fill sweeps and the clear after reset.
// ----------------------------------------------------------------------------
module cpfb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpfb_pkg::COLOR_W-1:0]  cfg_data,
  input  logic                          q_valid,
  input  cpfb_pkg::q_item_t             q_item,
  output logic                          q_pop,
  output cpfb_pkg::back_status_t        back_status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cpfb_pkg::COLOR_W-1:0]  out_read_value,
  output logic                          out_on_screen
);
  import cpfb_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  back_state_t        state_r, state_nxt;
  q_item_t            cur_r, cur_nxt;
  logic [ADDR_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic [COLOR_W-1:0] bg_r;
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_read_value_r;
  logic               out_on_screen_r;

  logic [COLOR_W-1:0] mem [STORE_DEPTH];
  logic [COLOR_W-1:0] rd_data_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  logic               out_free;
  logic               load_out;
  logic [COLOR_W-1:0] res_value;
  logic               res_on;
  logic               sweep_last;

  assign out_free   = !out_valid_r || out_ready;
  assign sweep_last = (sweep_cnt_r == LAST_ADDR);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (sweep_last) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid && out_free) begin
          case (q_item.op)
            OP_FILL:                     state_nxt = BK_FILL;
            OP_INVERT, OP_XOR, OP_READ:  state_nxt = BK_MODIFY;
            default:                     state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_MODIFY: state_nxt = BK_IDLE;
      BK_FILL: begin
        if (sweep_last) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = sweep_cnt_r;
    mem_wdata     = '0;
    mem_raddr     = q_item.addr;
    load_out      = 1'b0;
    res_value     = '0;
    res_on        = cur_r.on_screen;
    cur_nxt       = cur_r;
    sweep_cnt_nxt = sweep_cnt_r;
    case (state_r)
      BK_CLEAR: begin
        mem_we        = 1'b1;
        sweep_cnt_nxt = sweep_last ? '0 : sweep_cnt_r + 1'b1;
      end
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          res_on  = q_item.on_screen;
          case (q_item.op)
            OP_FILL: begin
              sweep_cnt_nxt = '0;
            end
            OP_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = q_item.addr;
              mem_wdata = q_item.color;
              load_out  = 1'b1;
            end
            OP_INVERT, OP_XOR, OP_READ: begin
              load_out = 1'b0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      BK_MODIFY: begin
        load_out  = 1'b1;
        mem_waddr = cur_r.addr;
        case (cur_r.op)
          OP_INVERT: begin
            mem_we    = 1'b1;
            mem_wdata = ~rd_data_r;
          end
          OP_XOR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_r ^ cur_r.color;
          end
          OP_READ: begin
            res_value = rd_data_r;
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      BK_FILL: begin
        mem_we        = 1'b1;
        mem_wdata     = bg_r;
        sweep_cnt_nxt = sweep_last ? '0 : sweep_cnt_r + 1'b1;
        load_out      = sweep_last;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
      bg_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        bg_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load_out) begin
      out_read_value_r <= res_value;
      out_on_screen_r  <= res_on;
    end
  end

  // Frame store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign cfg_ready            = 1'b1;
  assign back_status.clearing = (state_r == BK_CLEAR);
  assign out_valid            = out_valid_r;
  assign out_read_value       = out_read_value_r;
  assign out_on_screen        = out_on_screen_r;

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

  // Items leave the queue only from idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE))
    else $error("queue popped outside idle");

  // Output slot is empty while a read-modify-write completes
  a_modify_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MODIFY) |-> !out_valid_r)
    else $error("result pending during read-modify-write");

  // A sweep ends at the last address and returns to idle
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == BK_FILL || state_r == BK_CLEAR) && sweep_last)
      |=> (state_r == BK_IDLE && sweep_cnt_r == '0))
    else $error("sweep did not terminate cleanly");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for clipped_pixel_framebuffer_top
// Drives pixel requests and background color writes through the valid/ready
// ports. A scoreboard keeps its own image of the frame store and the expected
// result words in order. Random idle gaps are applied on both sides.
// ----------------------------------------------------------------------------

class pixel_scoreboard;
  typedef struct packed {
    logic [cpfb_pkg::COLOR_W-1:0] read_value;
    logic                         on_screen;
  } pixel_result_t;

  logic [cpfb_pkg::COLOR_W-1:0] frame_image [cpfb_pkg::STORE_DEPTH];
  logic [cpfb_pkg::COLOR_W-1:0] background;
  pixel_result_t                pending [$];
  int mismatches;
  int requests_seen;
  int results_seen;
  int fills_seen;
  int off_screen_seen;

  function new();
    foreach (frame_image[i]) frame_image[i] = '0;
    background      = '0;
    mismatches      = 0;
    requests_seen   = 0;
    results_seen    = 0;
    fills_seen      = 0;
    off_screen_seen = 0;
  endfunction

  function void set_background(logic [cpfb_pkg::COLOR_W-1:0] color);
    background = color;
  endfunction

  // Apply one accepted request to the image and queue its result word
  function void note_request(logic [cpfb_pkg::CMD_W-1:0]   cmd,
                             logic [cpfb_pkg::POS_W-1:0]   pos_x,
                             logic [cpfb_pkg::POS_W-1:0]   pos_y,
                             logic [cpfb_pkg::COLOR_W-1:0] color);
    int            col;
    int            row;
    int            addr;
    bit            hit;
    pixel_result_t want;
    col  = $signed(pos_x);
    row  = $signed(pos_y);
    hit  = (col >= 0) && (col < cpfb_pkg::SCREEN_COLUMNS) &&
           (row >= 0) && (row < cpfb_pkg::SCREEN_ROWS);
    want.read_value = '0;
    want.on_screen  = hit;
    if (cmd == cpfb_pkg::CMD_FILL) begin
      foreach (frame_image[i]) frame_image[i] = background;
      fills_seen++;
    end else if (hit) begin
      addr = row * cpfb_pkg::SCREEN_COLUMNS + col;
      case (cmd)
        cpfb_pkg::CMD_WRITE:  frame_image[addr] = color;
        cpfb_pkg::CMD_INVERT: frame_image[addr] = ~frame_image[addr];
        cpfb_pkg::CMD_XOR:    frame_image[addr] = frame_image[addr] ^ color;
        cpfb_pkg::CMD_READ:   want.read_value = frame_image[addr];
        default: ;
      endcase
    end
    if (!hit) off_screen_seen++;
    requests_seen++;
    pending.push_back(want);
  endfunction

  // Compare one result word with the oldest expectation
  function void check_result(logic [cpfb_pkg::COLOR_W-1:0] read_value, logic on_screen);
    pixel_result_t want;
    results_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word, read_value %h on_screen %b",
               $time, read_value, on_screen);
      mismatches++;
      return;
    end
    want = pending.pop_front();
    if (read_value !== want.read_value) begin
      $display("%0t: read_value mismatch, expected %h, actual %h",
               $time, want.read_value, read_value);
      mismatches++;
    end
    if (on_screen !== want.on_screen) begin
      $display("%0t: on_screen mismatch, expected %b, actual %b",
               $time, want.on_screen, on_screen);
      mismatches++;
    end
  endfunction
endclass

module tb;
  import cpfb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;
  localparam int FILL_LIMIT    = 24;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 200;
  localparam int SETTLE_CYCLES = STORE_DEPTH + 32;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   in_cmd;
  logic [POS_W-1:0]   in_pos_x;
  logic [POS_W-1:0]   in_pos_y;
  logic [COLOR_W-1:0] in_color;
  logic               out_valid;
  logic               out_ready;
  logic [COLOR_W-1:0] out_read_value;
  logic               out_on_screen;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COLOR_W-1:0] cfg_data;

  pixel_scoreboard sb;
  logic            calm;
  int              fills_issued;
  int              settings_written;

  clipped_pixel_framebuffer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_on_screen  (out_on_screen),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly short gaps, a few long ones, none in calm phases
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm) return 0;
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Watch both channels on every edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_cmd, in_pos_x, in_pos_y, in_color);
      if (out_valid && out_ready) sb.check_result(out_read_value, out_on_screen);
    end
  end

  // Stall the result side at random
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = idle_gap();
      end
    end
  end

  // Present one request word and hold it until taken; valid stays high after
  task automatic send_pixel(input logic [CMD_W-1:0] cmd,
                            input logic signed [POS_W-1:0] pos_x, pos_y,
                            input logic [COLOR_W-1:0] color);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_pos_x <= pos_x;
    in_pos_y <= pos_y;
    in_color <= color;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_background(input logic [COLOR_W-1:0] color);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_background(color);
    settings_written++;
  endtask

  // Drop valid, wait for every result, then let a fill run out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_request();
    int                      pick;
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [COLOR_W-1:0]      color;
    pick = $urandom_range(0, 999);
    if (pick < 12 && fills_issued < FILL_LIMIT) begin
      cmd = CMD_FILL;
      fills_issued++;
    end else if (pick < 270) cmd = CMD_WRITE;
    else if (pick < 390) cmd = CMD_INVERT;
    else if (pick < 530) cmd = CMD_XOR;
    else if (pick < 950) cmd = CMD_READ;
    else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));

    // Keep most points on screen, many in a small corner so reads hit writes
    px   = POS_W'($urandom_range(0, SCREEN_COLUMNS - 1));
    py   = POS_W'($urandom_range(0, SCREEN_ROWS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      px = POS_W'($urandom_range(0, 7));
      py = POS_W'($urandom_range(0, 3));
    end else if (pick < 80) begin
    end else if (pick < 85) begin
      px = POS_W'($urandom_range(1, 4));
      px = -px;
    end else if (pick < 90) begin
      px = POS_W'(SCREEN_COLUMNS + $urandom_range(0, 3));
    end else if (pick < 93) begin
      py = POS_W'($urandom_range(1, 4));
      py = -py;
    end else if (pick < 95) begin
      py = POS_W'(SCREEN_ROWS + $urandom_range(0, 3));
    end else begin
      px = POS_W'($urandom);
      py = POS_W'($urandom);
    end
    color = COLOR_W'($urandom);
    send_pixel(cmd, px, py, color);
  endtask

  initial begin
    logic [COLOR_W-1:0] shade;
    sb               = new();
    fills_issued     = 0;
    settings_written = 0;
    calm      <= 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_cmd    <= '0;
    in_pos_x  <= '0;
    in_pos_y  <= '0;
    in_color  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Background is taken while the store is still clearing
    write_background(8'hA5);

    // Directed: corners, every command, clipping edges, spare codes, fill
    send_pixel(CMD_READ,   0,  0,  8'h00);
    send_pixel(CMD_WRITE,  0,  0,  8'hFF);
    send_pixel(CMD_WRITE,  63, 0,  8'h01);
    send_pixel(CMD_WRITE,  0,  31, 8'h5A);
    send_pixel(CMD_WRITE,  63, 31, 8'h80);
    send_pixel(CMD_READ,   0,  0,  8'h00);
    send_pixel(CMD_INVERT, 63, 0,  8'h00);
    send_pixel(CMD_XOR,    0,  31, 8'hFF);
    send_pixel(CMD_READ,   63, 0,  8'h00);
    send_pixel(CMD_READ,   0,  31, 8'h00);
    send_pixel(CMD_WRITE,  -1, 0,  8'h11);
    send_pixel(CMD_WRITE,  64, 0,  8'h22);
    send_pixel(CMD_INVERT, 0,  -1, 8'h00);
    send_pixel(CMD_XOR,    0,  32, 8'h33);
    send_pixel(CMD_WRITE,  16'sh8000, 16'sh8000, 8'h44);
    send_pixel(CMD_WRITE,  16'sh7FFF, 16'sh7FFF, 8'h55);
    send_pixel(CMD_READ,   -1, 0,  8'h00);
    send_pixel(CMD_READ,   63, 31, 8'h00);
    send_pixel(CMD_SPARE_LO, 63, 31, 8'hFF);
    send_pixel(CMD_SPARE_MID, 5, 5, 8'hFF);
    send_pixel(CMD_SPARE_HI, 70, 40, 8'hFF);
    send_pixel(CMD_FILL,   64, 32, 8'h00);
    send_pixel(CMD_READ,   63, 31, 8'h00);
    send_pixel(CMD_FILL,   10, 10, 8'h00);
    send_pixel(CMD_READ,   5,  5,  8'h00);

    // Random phases, each under its own background color
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      shade = (phase == 0) ? 8'hFF : (phase == 1) ? 8'h00 : COLOR_W'($urandom);
      calm <= (phase == 2);
      write_background(shade);
      repeat (PHASE_WORDS) random_request();
    end
    drain_results();

    $display("covered %0d request words (%0d fills, %0d off screen), %0d result words",
             sb.requests_seen, sb.fills_seen, sb.off_screen_seen, sb.results_seen);
    $display("under %0d background settings", settings_written);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
